/* design/uida_pkg.sv */
// Shared types, codes and constants of the unique ID to slave ID allocator.
package uida_pkg;

  // Default number of table slots.
  localparam int TABLE_ENTRIES_DEF = 32;

  // Slot indexes share the width of the slave ID field, which bounds the table size.
  localparam int IDX_W = 8;

  // Operation codes.
  localparam logic [1:0] OP_ASSIGN  = 2'd0;
  localparam logic [1:0] OP_CHECK   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BOUND   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // Search token that walks the row of slot cells, one cell per cycle.
  typedef struct packed {
    logic             active;
    logic [1:0]       operation;
    logic [31:0]      uid;
    logic [IDX_W-1:0] slot_id;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
    logic             conflict;
  } token_t;

  // Write-back of a new binding, broadcast to all cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      uid;
  } bind_wr_t;

endpackage

/* design/uida_in_if.sv */
// Request channel carrying one allocator item: operation, unique ID and slave ID.
interface uida_in_if
  import uida_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] uid;
  logic [7:0]  slot_id;

  modport source (output valid, output operation, output uid, output slot_id, input ready);
  modport sink (input valid, input operation, input uid, input slot_id, output ready);
endinterface

/* design/uida_out_if.sv */
// Response channel carrying one allocator result item: status, assigned ID and conflict.
interface uida_out_if
  import uida_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] bound_id;
  logic       conflict;

  modport source (output valid, output status, output bound_id, output conflict, input ready);
  modport sink (input valid, input status, input bound_id, input conflict, output ready);
endinterface

/* design/uida_cell.sv */
// One slot of the allocator table: holds a unique ID and its used bit, updates the passing token.
module uida_cell
  import uida_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  token_t   tok_in,
  input  bind_wr_t bind_wr,
  output token_t   tok_out
);

  logic [31:0] entry;
  logic        used;
  logic        own_slot;
  token_t      tok_next;

  assign own_slot = (tok_in.slot_id == IDX_W'(INDEX));

  // Fold this slot into the token: first match, first free slot, and conflict check.
  always_comb begin
    tok_next = tok_in;
    if (tok_in.active) begin
      if (tok_in.operation == OP_ASSIGN) begin
        if (!tok_in.hit && used && (entry == tok_in.uid)) begin
          tok_next.hit     = 1'b1;
          tok_next.hit_idx = IDX_W'(INDEX);
        end
        if (!tok_in.free_ok && !used) begin
          tok_next.free_ok  = 1'b1;
          tok_next.free_idx = IDX_W'(INDEX);
        end
      end
      if ((tok_in.operation == OP_CHECK) && own_slot) begin
        tok_next.conflict = used && (entry != tok_in.uid);
      end
    end
  end

  // Token stage register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Used bit: set by a new binding, cleared by a release of this slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (bind_wr.en && (bind_wr.idx == IDX_W'(INDEX))) begin
      used <= 1'b1;
    end else if (tok_in.active && (tok_in.operation == OP_RELEASE) && own_slot) begin
      used <= 1'b0;
    end
  end

  // Stored unique ID; only meaningful while the used bit is set.
  always_ff @(posedge clk) begin
    if (bind_wr.en && (bind_wr.idx == IDX_W'(INDEX))) begin
      entry <= bind_wr.uid;
    end
  end

endmodule

/* design/uid_slave_id_allocator_core.sv */
// Top level of the allocator: token launch, row of slot cells, result and write-back control.
// Each item's search token walks the row of slot cells one cell per cycle, is captured at the
// end of the row, and its result is then loaded into the output register together with the
// write-back of a new binding, once the output register is free to take it. A new item is
// accepted only when no token is in the row, while the previous result may still wait in the
// output register. The table comes out of reset empty at once.
module uid_slave_id_allocator_core
  import uida_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst,
  uida_in_if.sink  req,
  uida_out_if.source rsp
);

  state_t      state;
  state_t      state_next;
  token_t      tok [TABLE_ENTRIES+1];
  token_t      res;
  bind_wr_t    bind_wr;
  logic        accept;
  logic        load_out;
  logic        in_range;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [4:0]  out_id;
  logic        out_conflict;
  logic [1:0]  res_status;
  logic [4:0]  res_id;
  logic        res_conflict;

  assign accept = req.valid && req.ready;

  // Launch token built from the accepted item.
  always_comb begin
    tok[0]           = '0;
    tok[0].active    = accept;
    tok[0].operation = req.operation;
    tok[0].uid       = req.uid;
    tok[0].slot_id   = req.slot_id;
  end

  // Row of slot cells.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    uida_cell #(
      .INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .bind_wr(bind_wr),
      .tok_out(tok[i+1])
    );
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (tok[TABLE_ENTRIES].active) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    req.ready = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      S_IDLE:   req.ready = 1'b1;
      S_SCAN:   req.ready = 1'b0;
      S_FINISH: load_out  = !out_valid || rsp.ready;
      default:  req.ready = 1'b0;
    endcase
  end

  // Capture the token at the end of the row.
  always_ff @(posedge clk) begin
    if (tok[TABLE_ENTRIES].active) begin
      res <= tok[TABLE_ENTRIES];
    end
  end

  assign in_range = ({1'b0, res.slot_id} < (IDX_W + 1)'(TABLE_ENTRIES));

  // Result decode and write-back of a new binding.
  always_comb begin
    res_status   = ST_INVALID;
    res_id       = '0;
    res_conflict = 1'b0;
    bind_wr.en   = 1'b0;
    bind_wr.idx  = res.free_idx;
    bind_wr.uid  = res.uid;
    unique case (res.operation)
      OP_ASSIGN: begin
        if (res.uid == '0) begin
          res_status = ST_INVALID;
        end else if (res.hit) begin
          res_status = ST_BOUND;
          res_id     = res.hit_idx[4:0];
        end else if (res.free_ok) begin
          res_status = ST_OK;
          res_id     = res.free_idx[4:0];
          bind_wr.en = load_out;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_CHECK: begin
        if (in_range) begin
          res_status   = ST_OK;
          res_conflict = res.conflict;
        end
      end
      OP_RELEASE: begin
        if (in_range) res_status = ST_OK;
      end
      default: res_status = ST_INVALID;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status   <= res_status;
      out_id       <= res_id;
      out_conflict <= res_conflict;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.bound_id = out_id;
  assign rsp.conflict = out_conflict;

  // An accepted item launches a token into the first cell on the next cycle.
  a_launch: assert property (@(posedge clk) disable iff (rst)
    accept |=> tok[1].active)
    else $error("accepted item did not enter the first cell");

  // Items are taken only when no token is at the end of the row.
  a_row_empty: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !tok[TABLE_ENTRIES].active)
    else $error("item accepted while a token is still in the row");

  // A binding is written back only while the result is being loaded.
  a_bind_on_load: assert property (@(posedge clk) disable iff (rst)
    bind_wr.en |-> (load_out && res.free_ok && !res.hit))
    else $error("binding written outside result load");

  // The output register is loaded only after a token has left the row.
  a_load_after_scan: assert property (@(posedge clk) disable iff (rst)
    load_out && !$past(load_out) |-> $past(state == S_SCAN) || $past(state == S_FINISH))
    else $error("result loaded without a finished scan");

endmodule
